@@ rtl/byte_pair_histogram_defines.svh @@
// Assertion macros shared by the byte pair histogram RTL.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef BYTE_PAIR_HISTOGRAM_DEFINES_SVH
`define BYTE_PAIR_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPH_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bph_pkg.sv @@
// Shared types and constants of the byte pair histogram.
// No dependencies; imported by bph_thresh and the top level.
`timescale 1ns / 1ps

package bph_pkg;

	localparam int THR_BITS       = 8;
	localparam int LEVEL_BITS     = 3;
	localparam int CFG_INDEX_BITS = 8;

	typedef enum logic [1:0] {
		ACT_FEED    = 2'd0,
		ACT_READ    = 2'd1,
		ACT_RESTART = 2'd2
	} action_t;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	typedef logic [THR_BITS-1:0]       thr_t;
	typedef logic [LEVEL_BITS-1:0]     level_t;

	localparam cfg_index_t REG_LEVEL4 = 8'd0;
	localparam cfg_index_t REG_LEVEL3 = 8'd1;
	localparam cfg_index_t REG_LEVEL2 = 8'd2;
	localparam cfg_index_t REG_LEVEL1 = 8'd3;

	localparam thr_t LEVEL4_RESET = 8'd100;
	localparam thr_t LEVEL3_RESET = 8'd50;
	localparam thr_t LEVEL2_RESET = 8'd10;
	localparam thr_t LEVEL1_RESET = 8'd5;

	localparam level_t LEVEL_0 = 3'd0;
	localparam level_t LEVEL_1 = 3'd1;
	localparam level_t LEVEL_2 = 3'd2;
	localparam level_t LEVEL_3 = 3'd3;
	localparam level_t LEVEL_4 = 3'd4;

	typedef struct packed {
		logic       valid;
		cfg_index_t index;
		thr_t       data;
	} cfg_write_t;

endpackage

@@ rtl/bph_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Read during a write to the same address returns the old contents.
`timescale 1ns / 1ps

module bph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/bph_thresh.sv @@
// Density threshold registers and the level compare for one cell count.
// Depends on bph_pkg for the write struct, register indexes and reset values.
`timescale 1ns / 1ps

module bph_thresh #(
	parameter int COUNT_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bph_pkg::cfg_write_t    cfg,
	input  logic [COUNT_BITS-1:0]  count,
	output bph_pkg::level_t        level
);

	import bph_pkg::*;

	localparam int CMP_BITS = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

	thr_t                level4_q;
	thr_t                level3_q;
	thr_t                level2_q;
	thr_t                level1_q;
	logic [CMP_BITS-1:0] count_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level4_q <= LEVEL4_RESET;
			level3_q <= LEVEL3_RESET;
			level2_q <= LEVEL2_RESET;
			level1_q <= LEVEL1_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LEVEL4: level4_q <= cfg.data;
				REG_LEVEL3: level3_q <= cfg.data;
				REG_LEVEL2: level2_q <= cfg.data;
				REG_LEVEL1: level1_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign count_ext = CMP_BITS'(count);

	// Test from the highest level down; the first exceeded threshold wins.
	always_comb begin
		if (count_ext > CMP_BITS'(level4_q)) begin
			level = LEVEL_4;
		end else if (count_ext > CMP_BITS'(level3_q)) begin
			level = LEVEL_3;
		end else if (count_ext > CMP_BITS'(level2_q)) begin
			level = LEVEL_2;
		end else if (count_ext > CMP_BITS'(level1_q)) begin
			level = LEVEL_1;
		end else begin
			level = LEVEL_0;
		end
	end

endmodule

@@ rtl/byte_pair_histogram.sv @@
// Top level of the byte pair histogram: pair tracking, counter RAM pipeline, output.
// Depends on bph_pkg, bph_ram, bph_thresh and byte_pair_histogram_defines.svh.
`timescale 1ns / 1ps
`include "byte_pair_histogram_defines.svh"

// Counts adjacent symbol pairs of a byte stream in a 2^(2*SYMBOL_BITS) entry
// counter RAM (row = newer byte, column = older byte), COUNT_BITS wide, wrapping.
// After reset a clearing pass zeroes the RAM one entry per cycle; in_stall stays
// high until it ends, while configuration writes are taken at any time. After that
// the block takes one transaction per cycle unless in_stall holds it: the
// read-modify-write of a feed goes through the RAM's registered read and a write
// back, with forwarding to a following access of the same cell. A read result
// passes through stage 1 and the output register to out_valid; while a result
// waits in the output register under out_stall, a further read blocks in the
// pipeline and in_stall rises.
module byte_pair_histogram #(
	parameter int SYMBOL_BITS = 8,
	parameter int COUNT_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            action,
	input  logic [7:0]            data_byte,
	input  logic [7:0]            read_row,
	input  logic [7:0]            read_col,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COUNT_BITS-1:0] cell_count,
	output bph_pkg::level_t       density_level,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  bph_pkg::cfg_index_t   cfg_index,
	input  bph_pkg::thr_t         cfg_data
);

	import bph_pkg::*;

	localparam int ADDR_BITS = 2 * SYMBOL_BITS;
	localparam int DEPTH     = 1 << ADDR_BITS;

	logic                   clearing_q;
	logic [ADDR_BITS-1:0]   clr_addr_q;
	logic [SYMBOL_BITS-1:0] prev_q;
	logic                   have_prev_q;

	logic                   s1_valid_q;
	logic                   s1_inc_q;
	logic [ADDR_BITS-1:0]   s1_addr_q;
	logic                   fwd_q;
	logic [COUNT_BITS-1:0]  fwd_data_q;

	logic                   out_valid_q;
	logic [COUNT_BITS-1:0]  cell_count_q;
	level_t                 density_q;

	logic                   in_accept;
	logic                   s1_advance;
	logic                   s1_write;
	logic                   s1_result;
	logic                   new_issue;
	logic                   new_inc;
	logic [ADDR_BITS-1:0]   new_addr;
	logic [SYMBOL_BITS-1:0] sym;

	logic                   ram_we;
	logic [ADDR_BITS-1:0]   ram_waddr;
	logic [COUNT_BITS-1:0]  ram_wdata;
	logic                   ram_re;
	logic [COUNT_BITS-1:0]  ram_rdata;
	logic [COUNT_BITS-1:0]  s1_data;
	logic [COUNT_BITS-1:0]  s1_sum;
	level_t                 s1_level;
	cfg_write_t             cfg_wr;

	// Handshakes
	assign cfg_ready  = 1'b1;
	assign s1_advance = s1_inc_q || !out_valid_q || !out_stall;
	assign in_stall   = clearing_q || (s1_valid_q && !s1_advance);
	assign in_accept  = in_valid && !in_stall;

	// Decode the incoming transaction into a RAM access
	assign sym = data_byte[SYMBOL_BITS-1:0];

	always_comb begin
		new_issue = 1'b0;
		new_inc   = 1'b0;
		new_addr  = {read_row[SYMBOL_BITS-1:0], read_col[SYMBOL_BITS-1:0]};
		case (action)
			ACT_FEED: begin
				new_issue = have_prev_q;
				new_inc   = 1'b1;
				new_addr  = {sym, prev_q};
			end
			ACT_READ: begin
				new_issue = 1'b1;
			end
			default: ;
		endcase
	end

	// Stage 1: RAM data is back, take the forwarded value if the cell was just written
	assign s1_data   = fwd_q ? fwd_data_q : ram_rdata;
	assign s1_sum    = s1_data + COUNT_BITS'(1);
	assign s1_write  = s1_valid_q && s1_inc_q;
	assign s1_result = s1_valid_q && !s1_inc_q && s1_advance;

	assign ram_re    = in_accept && new_issue;
	assign ram_we    = clearing_q || s1_write;
	assign ram_waddr = clearing_q ? clr_addr_q : s1_addr_q;
	assign ram_wdata = clearing_q ? '0 : s1_sum;

	bph_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH)
	) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (new_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		cfg_wr.valid = cfg_valid && cfg_ready;
		cfg_wr.index = cfg_index;
		cfg_wr.data  = cfg_data;
	end

	bph_thresh #(
		.COUNT_BITS (COUNT_BITS)
	) u_thresh (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_wr),
		.count  (s1_data),
		.level  (s1_level)
	);

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Previous symbol of the stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
		end else if (in_accept) begin
			case (action)
				ACT_FEED: begin
					prev_q      <= sym;
					have_prev_q <= 1'b1;
				end
				ACT_RESTART: have_prev_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// Stage 1 control; hold a blocked read in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_q      <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= new_issue;
			fwd_q      <= new_issue && s1_write && (s1_addr_q == new_addr);
		end else if (s1_advance) begin
			s1_valid_q <= 1'b0;
			fwd_q      <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			s1_inc_q   <= new_inc;
			s1_addr_q  <= new_addr;
			fwd_data_q <= s1_sum;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_result) begin
			cell_count_q <= s1_data;
			density_q    <= s1_level;
		end
	end

	assign out_valid     = out_valid_q;
	assign cell_count    = cell_count_q;
	assign density_level = density_q;

	`BPH_ASSERT_SAME(a_no_accept_clearing, clearing_q, !in_accept, "transaction accepted during clear")
	`BPH_ASSERT_SAME(a_clear_writes_zero, clearing_q, ram_we && ram_wdata == '0, "clear pass not writing zero")
	`BPH_ASSERT_SAME(a_fwd_only_on_access, fwd_q, s1_valid_q, "forward flag without stage 1 access")
	`BPH_ASSERT_NEXT(a_blocked_read_holds, s1_valid_q && !s1_advance, s1_valid_q && !s1_inc_q, "blocked read lost")
	`BPH_ASSERT_SAME(a_no_write_on_clear_and_s1, clearing_q, !s1_valid_q, "stage 1 active during clear")

endmodule
